// ===== rtl/oad_pkg.sv =====
// Shared types, codes and reset constants for the obstacle-avoiding drive sequencer.
// Used by oad_cfg_regs, oad_step and obstacle_avoid_drive_fsm_top; depends on nothing.
package oad_pkg;

  localparam int unsigned DistW  = 8;
  localparam int unsigned CmW    = 7;
  localparam int unsigned MsW    = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SpeedW = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CmW-1:0] DIST_MAX = 7'd100;

  localparam logic [SpeedW-1:0] SPEED_BACK   = 7'd50;
  localparam logic [SpeedW-1:0] SPEED_CRUISE = 7'd65;
  localparam logic [SpeedW-1:0] SPEED_STEER  = 7'd80;
  localparam logic [SpeedW-1:0] SPEED_STOP   = 7'd0;

  localparam logic [CmW-1:0] RST_FRONT_BLOCK = 7'd35;
  localparam logic [CmW-1:0] RST_SIDE_BLOCK  = 7'd20;
  localparam logic [CmW-1:0] RST_CRASH       = 7'd10;
  localparam logic [MsW-1:0] RST_AVOID_TMO   = 16'd40;
  localparam logic [MsW-1:0] RST_BACK_TIME   = 16'd250;
  localparam logic [CmW-1:0] RST_NEAR_WALL   = 7'd15;
  localparam logic [CmW-1:0] RST_OPEN_SIDE   = 7'd70;
  localparam logic [CmW-1:0] RST_BAL_MARGIN  = 7'd6;

  typedef enum logic [1:0] {
    MODE_SCAN  = 2'd0,
    MODE_AVOID = 2'd1,
    MODE_BACK  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    DIR_FRONT = 3'd0,
    DIR_BACK  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_STOP  = 3'd4
  } dir_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRONT_BLOCK = 3'd0,
    CFG_SIDE_BLOCK  = 3'd1,
    CFG_CRASH       = 3'd2,
    CFG_AVOID_TMO   = 3'd3,
    CFG_BACK_TIME   = 3'd4,
    CFG_NEAR_WALL   = 3'd5,
    CFG_OPEN_SIDE   = 3'd6,
    CFG_BAL_MARGIN  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CmW-1:0] front_block_cm;
    logic [CmW-1:0] side_block_cm;
    logic [CmW-1:0] crash_cm;
    logic [MsW-1:0] avoid_timeout_ms;
    logic [MsW-1:0] back_time_ms;
    logic [CmW-1:0] near_wall_cm;
    logic [CmW-1:0] open_side_cm;
    logic [CmW-1:0] balance_margin_cm;
  } cfg_t;

  typedef struct packed {
    logic              drive_valid;
    dir_t              direction;
    logic [SpeedW-1:0] speed_pct;
    mode_t             mode_after;
  } res_t;

  // No echo and anything beyond the sensor's useful range read as the far limit.
  function automatic logic [CmW-1:0] clean_dist(input logic [DistW-1:0] raw);
    logic [CmW-1:0] d;
    d = DIST_MAX;
    if (raw != '0 && raw <= {1'b0, DIST_MAX}) begin
      d = raw[CmW-1:0];
    end
    return d;
  endfunction

endpackage

// ===== rtl/oad_cfg_regs.sv =====
// Configuration register file for the drive sequencer: eight thresholds and timings.
// Depends on oad_pkg for the register indexes, reset values and the cfg_t bundle.
module oad_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  oad_pkg::cfg_idx_t              wr_idx,
  input  logic [oad_pkg::CfgDataW-1:0]   wr_data,
  output oad_pkg::cfg_t                  cfg
);

  oad_pkg::cfg_t cfg_r;
  oad_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        oad_pkg::CFG_FRONT_BLOCK: cfg_nxt.front_block_cm    = wr_data[oad_pkg::CmW-1:0];
        oad_pkg::CFG_SIDE_BLOCK:  cfg_nxt.side_block_cm     = wr_data[oad_pkg::CmW-1:0];
        oad_pkg::CFG_CRASH:       cfg_nxt.crash_cm          = wr_data[oad_pkg::CmW-1:0];
        oad_pkg::CFG_AVOID_TMO:   cfg_nxt.avoid_timeout_ms  = wr_data[oad_pkg::MsW-1:0];
        oad_pkg::CFG_BACK_TIME:   cfg_nxt.back_time_ms      = wr_data[oad_pkg::MsW-1:0];
        oad_pkg::CFG_NEAR_WALL:   cfg_nxt.near_wall_cm      = wr_data[oad_pkg::CmW-1:0];
        oad_pkg::CFG_OPEN_SIDE:   cfg_nxt.open_side_cm      = wr_data[oad_pkg::CmW-1:0];
        oad_pkg::CFG_BAL_MARGIN:  cfg_nxt.balance_margin_cm = wr_data[oad_pkg::CmW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.front_block_cm    <= oad_pkg::RST_FRONT_BLOCK;
      cfg_r.side_block_cm     <= oad_pkg::RST_SIDE_BLOCK;
      cfg_r.crash_cm          <= oad_pkg::RST_CRASH;
      cfg_r.avoid_timeout_ms  <= oad_pkg::RST_AVOID_TMO;
      cfg_r.back_time_ms      <= oad_pkg::RST_BACK_TIME;
      cfg_r.near_wall_cm      <= oad_pkg::RST_NEAR_WALL;
      cfg_r.open_side_cm      <= oad_pkg::RST_OPEN_SIDE;
      cfg_r.balance_margin_cm <= oad_pkg::RST_BAL_MARGIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/oad_step.sv =====
// Combinational decision for one sensor word: next mode, mark reload and drive command.
// Depends on oad_pkg for the mode and direction codes and the cfg_t and res_t bundles.
module oad_step (
  input  oad_pkg::cfg_t                 cfg,
  input  oad_pkg::mode_t                mode,
  input  logic [oad_pkg::TimeW-1:0]     mark_time,
  input  logic [oad_pkg::DistW-1:0]     left_dist,
  input  logic [oad_pkg::DistW-1:0]     center_dist,
  input  logic [oad_pkg::DistW-1:0]     right_dist,
  input  logic [oad_pkg::TimeW-1:0]     now_ms,
  output oad_pkg::res_t                 res,
  output logic                          mark_load
);

  logic [oad_pkg::CmW-1:0]   l_cm;
  logic [oad_pkg::CmW-1:0]   c_cm;
  logic [oad_pkg::CmW-1:0]   r_cm;
  logic [oad_pkg::CmW-1:0]   min_lc;
  logic [oad_pkg::CmW-1:0]   fmin;
  logic [oad_pkg::TimeW-1:0] elapsed;
  logic signed [oad_pkg::CmW+1:0] diff;
  logic signed [oad_pkg::CmW+1:0] margin;
  logic avoid_tmo;
  logic back_done;

  assign l_cm   = oad_pkg::clean_dist(left_dist);
  assign c_cm   = oad_pkg::clean_dist(center_dist);
  assign r_cm   = oad_pkg::clean_dist(right_dist);
  assign min_lc = (l_cm < c_cm) ? l_cm : c_cm;
  assign fmin   = (r_cm < min_lc) ? r_cm : min_lc;

  // Wrapping subtraction keeps the elapsed time right across a timestamp rollover.
  assign elapsed   = now_ms - mark_time;
  assign avoid_tmo = elapsed >= {{(oad_pkg::TimeW-oad_pkg::MsW){1'b0}}, cfg.avoid_timeout_ms};
  assign back_done = elapsed >= {{(oad_pkg::TimeW-oad_pkg::MsW){1'b0}}, cfg.back_time_ms};

  assign diff   = $signed({2'b00, l_cm}) - $signed({2'b00, r_cm});
  assign margin = $signed({2'b00, cfg.balance_margin_cm});

  always_comb begin
    res.drive_valid = 1'b0;
    res.direction   = oad_pkg::DIR_FRONT;
    res.speed_pct   = '0;
    res.mode_after  = mode;
    mark_load       = 1'b0;
    unique case (mode)
      oad_pkg::MODE_SCAN: begin
        res.drive_valid = 1'b1;
        if (c_cm < cfg.crash_cm) begin
          res.direction  = oad_pkg::DIR_BACK;
          res.speed_pct  = oad_pkg::SPEED_BACK;
          res.mode_after = oad_pkg::MODE_BACK;
          mark_load      = 1'b1;
        end else if (fmin < cfg.front_block_cm) begin
          res.speed_pct  = oad_pkg::SPEED_STEER;
          res.mode_after = oad_pkg::MODE_AVOID;
          mark_load      = 1'b1;
          // A blocked side wins; otherwise turn towards the clearly wider side, left when even.
          priority if (l_cm < cfg.side_block_cm) res.direction = oad_pkg::DIR_RIGHT;
          else if (r_cm < cfg.side_block_cm)     res.direction = oad_pkg::DIR_LEFT;
          else if (diff > margin)                res.direction = oad_pkg::DIR_LEFT;
          else if (diff < -margin)               res.direction = oad_pkg::DIR_RIGHT;
          else                                   res.direction = oad_pkg::DIR_LEFT;
        end else begin
          res.speed_pct = oad_pkg::SPEED_CRUISE;
          priority if (l_cm < cfg.near_wall_cm) res.direction = oad_pkg::DIR_RIGHT;
          else if (r_cm < cfg.near_wall_cm)     res.direction = oad_pkg::DIR_LEFT;
          else if (l_cm >= cfg.open_side_cm && r_cm < cfg.open_side_cm)
            res.direction = oad_pkg::DIR_LEFT;
          else if (r_cm >= cfg.open_side_cm && l_cm < cfg.open_side_cm)
            res.direction = oad_pkg::DIR_RIGHT;
          else
            res.direction = oad_pkg::DIR_FRONT;
        end
      end
      oad_pkg::MODE_AVOID: begin
        if (fmin > cfg.front_block_cm || avoid_tmo) begin
          res.mode_after = oad_pkg::MODE_SCAN;
        end
      end
      oad_pkg::MODE_BACK: begin
        if (back_done) begin
          res.drive_valid = 1'b1;
          res.direction   = oad_pkg::DIR_STOP;
          res.speed_pct   = oad_pkg::SPEED_STOP;
          res.mode_after  = oad_pkg::MODE_SCAN;
        end
      end
      default: begin
        res.mode_after = oad_pkg::MODE_SCAN;
      end
    endcase
  end

endmodule

// ===== rtl/obstacle_avoid_drive_fsm_top.sv =====
// Top level of the obstacle-avoiding drive sequencer: input register, decision, result register.
// Depends on oad_pkg, oad_cfg_regs and oad_step.
//
// Use of the block:
//   in_*   : one word per sensor sweep; in_tdata holds left, centre and right distance
//            (8 bits each) and the 32-bit millisecond timestamp.
//   out_*  : exactly one result word per input word; out_tuser is the drive-command
//            flag, out_tdata holds direction, speed in percent and the mode after the step.
//   cfg_*  : register writes (index 0..7, data in the low bits); always ready, and meant
//            to be used only while no word is in flight.
// The accepted word sits in the input register, and the decision is registered into the
// output register as the word advances, once the output register is empty or being emptied.
// One word per cycle unless stalled; the mode and mark time update as a word moves from
// the input register to the output register, so back-to-back words see each other's state.
// When the receiver stalls, the output register holds its word and the input register
// still takes one more word; after that in_tready drops until out_tready returns.
// Synchronous reset clears both stages, sets the mode to scan, the mark time to zero and
// the registers to their default thresholds.
module obstacle_avoid_drive_fsm_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // left_dist[7:0], center_dist[15:8], right_dist[23:16], now_ms[55:24]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // drive_valid[0]
  output logic        out_tuser,
  // direction[2:0], speed_pct[9:3], mode_after[11:10], zero fill [15:12]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  oad_pkg::cfg_t  cfg;
  oad_pkg::res_t  res;
  logic           mark_load;
  logic           advance;

  logic           in_vld_r;
  logic [55:0]    in_word_r;
  logic           out_vld_r;
  oad_pkg::res_t  out_res_r;
  oad_pkg::mode_t mode_r;
  oad_pkg::mode_t mode_nxt;
  logic [oad_pkg::TimeW-1:0] mark_r;
  logic [oad_pkg::TimeW-1:0] mark_nxt;

  assign cfg_ready = 1'b1;

  oad_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (oad_pkg::cfg_idx_t'(cfg_index)),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  oad_step u_step (
    .cfg         (cfg),
    .mode        (mode_r),
    .mark_time   (mark_r),
    .left_dist   (in_word_r[7:0]),
    .center_dist (in_word_r[15:8]),
    .right_dist  (in_word_r[23:16]),
    .now_ms      (in_word_r[55:24]),
    .res         (res),
    .mark_load   (mark_load)
  );

  // The held word moves on when the output register is empty or being emptied.
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  assign mode_nxt = advance ? res.mode_after : mode_r;
  assign mark_nxt = (advance && mark_load) ? in_word_r[55:24] : mark_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r    <= oad_pkg::MODE_SCAN;
      mark_r    <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      mode_r <= mode_nxt;
      mark_r <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_word_r <= in_tdata;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.drive_valid;
  assign out_tdata  = {4'b0000, out_res_r.mode_after, out_res_r.speed_pct,
                       out_res_r.direction};

`ifndef ASSERT_OFF
  // Without a command the direction and speed fields are zero.
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[9:0] == '0))
    else $error("result without command carries non-zero direction or speed");

  // A stop command always ends back-up and returns to scan.
  a_stop_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && out_res_r.direction == oad_pkg::DIR_STOP) |->
      (out_res_r.mode_after == oad_pkg::MODE_SCAN && out_res_r.speed_pct == oad_pkg::SPEED_STOP))
    else $error("stop command without return to scan");

  // A word decided in avoid never issues a command.
  a_avoid_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && mode_r == oad_pkg::MODE_AVOID) |=> (out_vld_r && !out_res_r.drive_valid))
    else $error("command issued from avoid");

  // The mode register follows the mode reported with each result.
  a_mode_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (mode_r == out_res_r.mode_after))
    else $error("mode register differs from reported mode");

  // The mark time only changes on a word that enters back-up or avoid.
  a_mark_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mark_r != $past(mark_r)) |-> ($past(advance) && $past(mode_r) == oad_pkg::MODE_SCAN))
    else $error("mark time changed outside scan");
`endif

endmodule
